// File: rtl/core/oximeter_datum_nibble_decoder_top_defines.svh
// Assertion helpers used by the checker file.
`ifndef OXIMETER_DATUM_NIBBLE_DECODER_TOP_DEFINES_SVH
`define OXIMETER_DATUM_NIBBLE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is held.
`define ONDD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ondd check failed");

// Next-cycle implication, sampled on clk, off while reset is held.
`define ONDD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ondd check failed");

`endif

// File: rtl/core/ondd_pkg.sv
package ondd_pkg;

  localparam int GROUP_BYTES = 14;
  localparam int LEN_W       = 17;
  localparam int VAL_W       = 8;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic             MODE_AUTO   = 1'b0;
  localparam logic             MODE_MANUAL = 1'b1;
  localparam logic [VAL_W-1:0] ART_SPO2    = 8'd127;
  localparam logic [VAL_W-1:0] ART_PULSE   = 8'd255;
  localparam logic [VAL_W-1:0] BYTE_ART    = 8'h7f;
  localparam logic [3:0]       NIB_ADJUST  = 4'h7;
  localparam logic [3:0]       NIB_ART     = 4'hf;

  typedef enum logic [1:0] {
    REG_DECODE_MODE = 2'd0,
    REG_MEAS_KIND   = 2'd1,
    REG_REC_LEN     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             decode_mode;
    logic             measurement_kind;
    logic [LEN_W-1:0] record_length;
  } cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] index;
    logic             last;
    logic             done;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } pair_t;

endpackage

// File: rtl/core/ondd_in_if.sv
interface ondd_in_if;
  import ondd_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       flag_bit;
  logic       restart;

  modport source (output valid, data_byte, flag_bit, restart, input ready);
  modport sink   (input valid, data_byte, flag_bit, restart, output ready);
endinterface

// File: rtl/core/ondd_out_if.sv
interface ondd_out_if;
  import ondd_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] sample_value;
  logic [LEN_W-1:0] sample_index;
  logic             last_of_run;
  logic             record_done;

  modport source (output valid, sample_value, sample_index, last_of_run, record_done,
                  input ready);
  modport sink   (input valid, sample_value, sample_index, last_of_run, record_done,
                  output ready);
endinterface

// File: rtl/core/oximeter_datum_nibble_decoder_top.sv
// Stored-record oximeter sample decoder.
// in_bus takes one record byte per beat with its flag bit and a restart
// bit; restart reloads the sample count from record_length and realigns
// the manual group before that byte is decoded. out_bus gives zero, one
// or two samples per byte, each with its store index (count after
// decrement), last_of_run on the final sample of the byte and
// record_done on the sample with index zero. Bytes arriving with the
// count at zero produce nothing.
// Bytes are registered in the input register, samples in the output stage.
// Throughput: one byte per cycle if it yields at most one sample and
// out_bus is ready; the single result port slows bytes that yield two.
// Reset (rst_n low, synchronous) clears registers and decoder state and
// empties both stages. When the receiver stalls, the two-entry output
// stage holds its samples, the input register holds the next byte, and
// in_bus.ready drops while the held byte's samples cannot be loaded.
// Registers (APB, 32-bit): 0x0 decode_mode, 0x4 measurement_kind,
// 0x8 record_length. Write them only while the block is idle.
module oximeter_datum_nibble_decoder_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ondd_pkg::ADDR_W-1:0] paddr,
  input  logic [ondd_pkg::DATA_W-1:0] pwdata,
  output logic [ondd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  ondd_in_if.sink                     in_bus,
  ondd_out_if.source                  out_bus
);
  import ondd_pkg::*;

  cfg_t  cfg;
  pair_t pair;
  logic  push;
  logic  load_ok;

  ondd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ondd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .in_bus    (in_bus),
    .pair_o    (pair),
    .push_o    (push),
    .load_ok_i (load_ok)
  );

  ondd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .pair_i    (pair),
    .push_i    (push),
    .load_ok_o (load_ok),
    .out_bus   (out_bus)
  );
endmodule

// File: rtl/core/ondd_cfg.sv
module ondd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ondd_pkg::ADDR_W-1:0] paddr,
  input  logic [ondd_pkg::DATA_W-1:0] pwdata,
  output logic [ondd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output ondd_pkg::cfg_t              cfg_o
);
  import ondd_pkg::*;

  logic             decode_mode_r;
  logic             meas_kind_r;
  logic [LEN_W-1:0] rec_len_r;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // write the addressed register in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
      meas_kind_r   <= 1'b0;
      rec_len_r     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_DECODE_MODE: decode_mode_r <= pwdata[0];
        REG_MEAS_KIND:   meas_kind_r   <= pwdata[0];
        REG_REC_LEN:     rec_len_r     <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_DECODE_MODE: prdata = {{(DATA_W-1){1'b0}}, decode_mode_r};
      REG_MEAS_KIND:   prdata = {{(DATA_W-1){1'b0}}, meas_kind_r};
      REG_REC_LEN:     prdata = {{(DATA_W-LEN_W){1'b0}}, rec_len_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.decode_mode      = decode_mode_r;
  assign cfg_o.measurement_kind = meas_kind_r;
  assign cfg_o.record_length    = rec_len_r;
endmodule

// File: rtl/core/ondd_decode.sv
module ondd_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  ondd_pkg::cfg_t  cfg_i,
  ondd_in_if.sink         in_bus,
  output ondd_pkg::pair_t pair_o,
  output logic            push_o,
  input  logic            load_ok_i
);
  import ondd_pkg::*;

  // input register
  logic       in_v_r;
  logic [7:0] byte_r;
  logic       flag_r;
  logic       restart_r;

  // decoder state
  logic [VAL_W-1:0] base_value_r,     base_value_nxt;
  logic             adj_pending_r,    adj_pending_nxt;
  logic [VAL_W-1:0] running_sample_r, running_sample_nxt;
  logic [3:0]       group_pos_r,      group_pos_nxt;
  logic [LEN_W-1:0] samples_left_r,   samples_left_nxt;

  logic             consume;
  logic             in_acc;
  logic [1:0]       want;
  logic [VAL_W-1:0] v0, v1;
  logic [LEN_W-1:0] idx0, idx1;
  logic             two_ok;

  // decode one byte against the current state
  always_comb begin
    logic [LEN_W-1:0] sl0;
    logic [3:0]       gp0;
    logic [3:0]       hi, lo;
    logic [VAL_W-1:0] art, rs1, rs2;
    logic [4:0]       pos_inc;
    logic             art_byte;

    sl0      = restart_r ? cfg_i.record_length : samples_left_r;
    gp0      = restart_r ? 4'd0 : group_pos_r;
    hi       = byte_r[7:4];
    lo       = byte_r[3:0];
    art      = cfg_i.measurement_kind ? ART_PULSE : ART_SPO2;
    art_byte = flag_r && (byte_r == BYTE_ART);
    pos_inc  = {1'b0, gp0} + 5'd1;
    rs1      = flag_r ? running_sample_r - {4'b0, hi} : running_sample_r + {4'b0, hi};
    rs2      = lo[3] ? rs1 - {5'b0, lo[2:0]} : rs1 + {4'b0, lo};

    base_value_nxt     = base_value_r;
    adj_pending_nxt    = adj_pending_r;
    running_sample_nxt = running_sample_r;
    group_pos_nxt      = gp0;
    v0                 = '0;
    v1                 = '0;
    want               = 2'd0;

    if (sl0 != '0) begin
      if (cfg_i.decode_mode == MODE_AUTO) begin
        if (flag_r && hi == NIB_ADJUST) begin
          // base adjustment pair, no sample
          adj_pending_nxt = !adj_pending_r;
          base_value_nxt  = adj_pending_r ? {lo, 4'b0} : base_value_r + {4'b0, lo};
        end else begin
          v0   = base_value_r - ({4'b0, hi} + {4'b0, flag_r, 3'b0});
          v1   = base_value_r - {4'b0, lo};
          want = (lo != NIB_ART) ? 2'd2 : 2'd1;
        end
      end else begin
        group_pos_nxt = (pos_inc >= 5'(GROUP_BYTES)) ? 4'd0 : pos_inc[3:0];
        if (gp0 == 4'd0) begin
          // group head: absolute value
          running_sample_nxt = art_byte ? byte_r : byte_r + {flag_r, 7'b0};
          v0                 = art_byte ? art : byte_r + {flag_r, 7'b0};
          want               = 2'd1;
        end else if (art_byte) begin
          v0   = art;
          v1   = art;
          want = 2'd2;
        end else begin
          v0   = rs1;
          want = 2'd2;
          if (lo == NIB_ART) begin
            v1                 = art;
            running_sample_nxt = rs1;
          end else begin
            v1                 = rs2;
            running_sample_nxt = rs2;
          end
        end
      end
    end

    // cut the run where the count runs out
    idx0   = sl0 - LEN_W'(1);
    idx1   = sl0 - LEN_W'(2);
    two_ok = (want == 2'd2) && (idx0 != '0);
    if (want == 2'd0) begin
      samples_left_nxt = sl0;
    end else if (two_ok) begin
      samples_left_nxt = idx1;
    end else begin
      samples_left_nxt = idx0;
    end
  end

  assign pair_o.n        = (want == 2'd0) ? 2'd0 : (two_ok ? 2'd2 : 2'd1);
  assign pair_o.r0.value = v0;
  assign pair_o.r0.index = idx0;
  assign pair_o.r0.last  = !two_ok;
  assign pair_o.r0.done  = (idx0 == '0);
  assign pair_o.r1.value = v1;
  assign pair_o.r1.index = idx1;
  assign pair_o.r1.last  = 1'b1;
  assign pair_o.r1.done  = (idx1 == '0);

  assign consume      = in_v_r && ((want == 2'd0) || load_ok_i);
  assign push_o       = in_v_r && (want != 2'd0) && load_ok_i;
  assign in_bus.ready = !in_v_r || consume;
  assign in_acc       = in_bus.valid && in_bus.ready;

  // hold the input beat until decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_acc) begin
      in_v_r <= 1'b1;
    end else if (consume) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r    <= in_bus.data_byte;
      flag_r    <= in_bus.flag_bit;
      restart_r <= in_bus.restart;
    end
  end

  // advance state once the byte is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_value_r     <= '0;
      adj_pending_r    <= 1'b1;
      running_sample_r <= '0;
      group_pos_r      <= '0;
      samples_left_r   <= '0;
    end else if (consume) begin
      base_value_r     <= base_value_nxt;
      adj_pending_r    <= adj_pending_nxt;
      running_sample_r <= running_sample_nxt;
      group_pos_r      <= group_pos_nxt;
      samples_left_r   <= samples_left_nxt;
    end
  end
endmodule

// File: rtl/core/ondd_out_stage.sv
module ondd_out_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  ondd_pkg::pair_t pair_i,
  input  logic            push_i,
  output logic            load_ok_o,
  ondd_out_if.source      out_bus
);
  import ondd_pkg::*;

  result_t    slot0_r;
  result_t    slot1_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign pop       = (cnt_r != 2'd0) && out_bus.ready;
  assign load_ok_o = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);

  // load a pair, or drain one beat at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push_i) begin
      cnt_r <= pair_i.n;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      slot0_r <= pair_i.r0;
      slot1_r <= pair_i.r1;
    end else if (pop && cnt_r == 2'd2) begin
      slot0_r <= slot1_r;
    end
  end

  assign out_bus.valid        = (cnt_r != 2'd0);
  assign out_bus.sample_value = slot0_r.value;
  assign out_bus.sample_index = slot0_r.index;
  assign out_bus.last_of_run  = slot0_r.last;
  assign out_bus.record_done  = slot0_r.done;
endmodule

// File: rtl/core/ondd_checker.sv
`include "oximeter_datum_nibble_decoder_top_defines.svh"

module ondd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ondd_pkg::VAL_W-1:0]  sample_value,
  input logic [ondd_pkg::LEN_W-1:0]  sample_index,
  input logic                        last_of_run,
  input logic                        record_done
);
  import ondd_pkg::*;

  // a stalled beat holds
  `ONDD_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(sample_value) && $stable(sample_index) && $stable(last_of_run))

  // the final sample carries index zero and closes its run
  `ONDD_ASSERT_IMP(a_done_idx, out_valid,
    (record_done == (sample_index == '0)) && (!record_done || last_of_run))

  // the second sample of a byte follows straight after the first
  `ONDD_ASSERT_NXT(a_run_cont, out_valid && out_ready && !last_of_run, out_valid)
endmodule

bind oximeter_datum_nibble_decoder_top ondd_checker u_ondd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .sample_value (out_bus.sample_value),
  .sample_index (out_bus.sample_index),
  .last_of_run  (out_bus.last_of_run),
  .record_done  (out_bus.record_done)
);
